### src/voxel_ray_traversal_assert.svh
// ============================================================================
// Assertion macros for the voxel ray traversal block
// Concurrent checks on the block clock; they fall away when SYNTH is set.
// ============================================================================
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define VRT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, held off during reset.
`define VRT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRT_IMPLY(lbl, ante, cons, msg)
`define VRT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/vrt_pkg.sv
// ============================================================================
// vrt_pkg
// Shared constants, types and codes of the voxel ray traversal block.
// ============================================================================
package vrt_pkg;

  // Grid geometry.
  localparam int MAX_DIM = 32;
  localparam int CW      = $clog2(MAX_DIM);
  localparam int ADDR_W  = 3 * CW;
  localparam int ROW_W   = 2 * CW;
  localparam int ROWS    = MAX_DIM * MAX_DIM;
  localparam int CELLS   = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int SIZE_W  = 6;
  localparam int CPOS_W  = CW + 2;

  // Fixed-point widths.
  localparam int FRAC    = 16;
  localparam int T_W     = 64;
  localparam int NUM_W   = 34;
  localparam int MAG_W   = NUM_W - 1;
  localparam int DVD_W   = MAG_W + FRAC;
  localparam int DEN_W   = 18;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int PROD_W  = DEN_W + 33;
  localparam int P_W     = 36;

  // Walk step limit.
  localparam int GUARD_LIMIT = 3 * MAX_DIM + 4;
  localparam int GUARD_W     = $clog2(GUARD_LIMIT + 1);

  localparam logic signed [T_W-1:0] NO_BOUNDARY = T_W'(64'sd1 <<< 62);

  // Configuration bus.
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RAY   = 1'b1;

  // Face codes.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] FACE_NONE = 2'b00;
  localparam logic [1:0] FACE_POS  = 2'b01;
  localparam logic [1:0] FACE_NEG  = 2'b11;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [4:0]  cell_z;
    logic [31:0] cell_color;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [17:0] dir_z;
    logic [31:0] max_t;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_t;
    logic [31:0] hit_color;
    logic [1:0]  face_axis;
    logic [1:0]  face_sign;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [4:0]  hit_z;
  } res_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       color;
  } grid_req_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num_mag;
    logic             num_neg;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic signed [T_W-1:0] quo;
  } div_rsp_t;

endpackage

### src/vrt_div.sv
// ============================================================================
// vrt_div
// Restoring divider, one quotient bit a cycle: (num * 2^16) / den, truncated
// toward zero, as a signed 64-bit result.
// ============================================================================
module vrt_div (
  input  logic               clk,
  input  logic               rst,
  input  vrt_pkg::div_req_t  req,
  output vrt_pkg::div_rsp_t  rsp
);

  logic                             busy;
  logic                             done;
  logic [vrt_pkg::CNT_W-1:0]        cnt;
  logic [vrt_pkg::DVD_W-1:0]        quo;
  logic [vrt_pkg::DEN_W:0]          rem;
  logic [vrt_pkg::DEN_W-1:0]        den;
  logic                             neg;
  logic [vrt_pkg::DEN_W:0]          rem_sh;
  logic [vrt_pkg::DEN_W:0]          diff;
  logic [vrt_pkg::DEN_W-1:0]        den_mag;
  logic signed [vrt_pkg::T_W-1:0]   quo_ext;

  // Divisor magnitude taken at start.
  assign den_mag = req.den[vrt_pkg::DEN_W-1] ? (~req.den + 1'b1) : req.den;

  // One restoring step.
  assign rem_sh = {rem[vrt_pkg::DEN_W-1:0], quo[vrt_pkg::DVD_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= vrt_pkg::CNT_W'(vrt_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == vrt_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= {req.num_mag, {vrt_pkg::FRAC{1'b0}}};
      rem <= '0;
      den <= den_mag;
      neg <= req.num_neg ^ req.den[vrt_pkg::DEN_W-1];
    end else if (busy) begin
      if (!diff[vrt_pkg::DEN_W]) begin
        rem <= diff;
        quo <= {quo[vrt_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[vrt_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  // Apply the sign of the quotient.
  assign quo_ext = $signed({{(vrt_pkg::T_W - vrt_pkg::DVD_W){1'b0}}, quo});
  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = neg ? -quo_ext : quo_ext;

endmodule

### src/vrt_grid.sv
// ============================================================================
// vrt_grid
// Voxel store: occupancy rows of one bit per x cell and a colour per cell,
// both read through a register, so the data follows in the cycle after the
// read request. Occupancy is cleared row by row after reset.
// ============================================================================
module vrt_grid (
  input  logic                clk,
  input  logic                rst,
  input  vrt_pkg::grid_req_t  req,
  output logic                occ_bit,
  output logic [31:0]         color,
  output logic                clearing
);

  logic [vrt_pkg::MAX_DIM-1:0] occ_mem [vrt_pkg::ROWS];
  logic [31:0]                 color_mem [vrt_pkg::CELLS];
  logic [vrt_pkg::ROW_W-1:0]   clr_row;
  logic [vrt_pkg::MAX_DIM-1:0] occ_row_q;
  logic [vrt_pkg::CW-1:0]      bit_q;
  logic [vrt_pkg::ROW_W-1:0]   row;
  logic [vrt_pkg::CW-1:0]      col;
  logic [vrt_pkg::MAX_DIM-1:0] mask;

  assign row  = req.addr[vrt_pkg::ADDR_W-1:vrt_pkg::CW];
  assign col  = req.addr[vrt_pkg::CW-1:0];
  assign mask = {{(vrt_pkg::MAX_DIM-1){1'b0}}, 1'b1} << col;

  // Clearing pass over the occupancy rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == vrt_pkg::ROW_W'(vrt_pkg::ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Occupancy memory: a write sets one bit of the row read just before.
  always_ff @(posedge clk) begin
    if (clearing) begin
      occ_mem[clr_row] <= '0;
    end else if (req.wr) begin
      occ_mem[row] <= occ_row_q | mask;
    end
    if (req.rd) begin
      occ_row_q <= occ_mem[row];
      bit_q     <= col;
    end
  end

  // Colour memory.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      color_mem[req.addr] <= req.color;
    end
    if (req.rd) begin
      color <= color_mem[req.addr];
    end
  end

  assign occ_bit = occ_row_q[bit_q];

endmodule

### src/vrt_ctrl.sv
// ============================================================================
// vrt_ctrl
// Request sequencer: voxel writes as read-modify-write of the grid, and rays
// as slab clipping, entry setup and a cell-by-cell walk over the grid.
// ============================================================================
module vrt_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_fire,
  input  vrt_pkg::item_t                       item,
  input  logic [2:0][vrt_pkg::SIZE_W-1:0]      sz,
  output logic                                 idle,
  output vrt_pkg::grid_req_t                   grid_req,
  input  logic                                 occ_bit,
  input  logic [31:0]                          grid_color,
  output vrt_pkg::div_req_t                    div_req,
  input  vrt_pkg::div_rsp_t                    div_rsp,
  output logic                                 res_valid,
  output vrt_pkg::res_t                        res,
  input  logic                                 res_ack
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WR_RD    = 4'd1;
  localparam logic [3:0] S_WR_WB    = 4'd2;
  localparam logic [3:0] S_SLAB     = 4'd3;
  localparam logic [3:0] S_SLAB_T0  = 4'd4;
  localparam logic [3:0] S_SLAB_T1  = 4'd5;
  localparam logic [3:0] S_SLAB_UPD = 4'd6;
  localparam logic [3:0] S_ENT_MUL  = 4'd7;
  localparam logic [3:0] S_ENT_CELL = 4'd8;
  localparam logic [3:0] S_ENT_TN   = 4'd9;
  localparam logic [3:0] S_ENT_TD   = 4'd10;
  localparam logic [3:0] S_WALK_RD  = 4'd11;
  localparam logic [3:0] S_WALK_CHK = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]                          state;
  logic [1:0]                          ax;
  logic [4:0]                          wx, wy, wz;
  logic [31:0]                         wcolor;
  logic [2:0][31:0]                    o;
  logic [2:0][17:0]                    d;
  logic signed [vrt_pkg::T_W-1:0]      tmin, tmax, t0, t1, cur;
  logic [1:0]                          face_axis, face_sign;
  logic signed [vrt_pkg::PROD_W-1:0]   prod;
  logic signed [vrt_pkg::CPOS_W-1:0]   cpos   [3];
  logic signed [vrt_pkg::T_W-1:0]      tnext  [3];
  logic signed [vrt_pkg::T_W-1:0]      tdelta [3];
  logic [vrt_pkg::GUARD_W-1:0]         guard;

  // Combinational helpers.
  logic signed [31:0]                  cur_o;
  logic signed [17:0]                  cur_d;
  logic [vrt_pkg::SIZE_W-1:0]          cur_s;
  logic                                d_zero, d_pos;
  logic signed [vrt_pkg::NUM_W-1:0]    o_ext, s_fix, num_t0, num_t1, num_tn;
  logic                                par_out;
  logic signed [vrt_pkg::T_W-1:0]      lo, hi, ntmin, ntmax;
  logic [1:0]                          lo_sign;
  logic signed [vrt_pkg::P_W-1:0]      p;
  logic signed [19:0]                  cfl;
  logic [vrt_pkg::SIZE_W-1:0]          s_m1, cval, bound;
  logic                                any_zero, in_size, out_of_grid;
  logic [1:0]                          k;
  logic signed [vrt_pkg::T_W-1:0]      cur_new;
  logic [31:0]                         t_sat;

  // Build a divider request from a signed numerator and a divisor.
  function automatic vrt_pkg::div_req_t mk_div(input logic signed [vrt_pkg::NUM_W-1:0] num,
                                               input logic [17:0] den);
    vrt_pkg::div_req_t r;
    logic [vrt_pkg::NUM_W-1:0] m;
    m         = num[vrt_pkg::NUM_W-1] ? -num : num;
    r.start   = 1'b1;
    r.num_mag = m[vrt_pkg::MAG_W-1:0];
    r.num_neg = num[vrt_pkg::NUM_W-1];
    r.den     = den;
    return r;
  endfunction

  // Operands of the axis in hand.
  always_comb begin
    cur_o  = $signed(o[ax]);
    cur_d  = $signed(d[ax]);
    cur_s  = sz[ax];
    d_zero = (cur_d == 18'sd0);
    d_pos  = !cur_d[17] && !d_zero;
    o_ext  = vrt_pkg::NUM_W'(cur_o);
    s_fix  = $signed({{(vrt_pkg::NUM_W - vrt_pkg::SIZE_W - vrt_pkg::FRAC){1'b0}},
                      cur_s, {vrt_pkg::FRAC{1'b0}}});
    num_t0 = -o_ext;
    num_t1 = s_fix - o_ext;
    par_out = cur_o[31] || (o_ext > s_fix);
  end

  // Slab interval update.
  always_comb begin
    if (t0 > t1) begin
      lo      = t1;
      hi      = t0;
      lo_sign = vrt_pkg::FACE_POS;
    end else begin
      lo      = t0;
      hi      = t1;
      lo_sign = vrt_pkg::FACE_NEG;
    end
    ntmin = (lo > tmin) ? lo : tmin;
    ntmax = (hi < tmax) ? hi : tmax;
  end

  // Entry cell of the axis in hand and its first boundary.
  always_comb begin
    p    = vrt_pkg::P_W'(cur_o) + vrt_pkg::P_W'(prod >>> vrt_pkg::FRAC);
    cfl  = p[vrt_pkg::P_W-1:vrt_pkg::FRAC];
    s_m1 = cur_s - 1'b1;
    if (cfl[19]) begin
      cval = '0;
    end else if (cfl > $signed({14'b0, s_m1})) begin
      cval = s_m1;
    end else begin
      cval = cfl[vrt_pkg::SIZE_W-1:0];
    end
    bound  = d_pos ? cval + 1'b1 : cval;
    num_tn = $signed({{(vrt_pkg::NUM_W - vrt_pkg::SIZE_W - vrt_pkg::FRAC){1'b0}},
                      bound, {vrt_pkg::FRAC{1'b0}}}) - o_ext;
  end

  // Walk decisions.
  always_comb begin
    any_zero = (sz[0] == '0) || (sz[1] == '0) || (sz[2] == '0);
    in_size  = ({1'b0, item.cell_x} < sz[0]) && ({1'b0, item.cell_y} < sz[1]) &&
               ({1'b0, item.cell_z} < sz[2]);
    out_of_grid = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (cpos[i][vrt_pkg::CPOS_W-1] ||
          cpos[i] >= $signed({1'b0, sz[i]})) begin
        out_of_grid = 1'b1;
      end
    end
    if (tnext[0] < tnext[1] && tnext[0] < tnext[2]) begin
      k = vrt_pkg::AXIS_X;
    end else if (tnext[1] < tnext[2]) begin
      k = vrt_pkg::AXIS_Y;
    end else begin
      k = vrt_pkg::AXIS_Z;
    end
    cur_new = tnext[k];
    if (cur[vrt_pkg::T_W-1]) begin
      t_sat = '0;
    end else if (|cur[vrt_pkg::T_W-2:32]) begin
      t_sat = '1;
    end else begin
      t_sat = cur[31:0];
    end
  end

  // Memory and divider requests.
  always_comb begin
    grid_req = '0;
    div_req  = '0;
    case (state)
      S_WR_RD: begin
        grid_req.rd   = 1'b1;
        grid_req.addr = {wz, wy, wx};
      end
      S_WR_WB: begin
        grid_req.wr    = 1'b1;
        grid_req.addr  = {wz, wy, wx};
        grid_req.color = wcolor;
      end
      S_SLAB: begin
        if (!d_zero) begin
          div_req = mk_div(num_t0, d[ax]);
        end
      end
      S_SLAB_T0: begin
        if (div_rsp.done) begin
          div_req = mk_div(num_t1, d[ax]);
        end
      end
      S_ENT_CELL: begin
        if (!d_zero) begin
          div_req = mk_div(num_tn, d[ax]);
        end
      end
      S_ENT_TN: begin
        if (div_rsp.done) begin
          // 2^32 / |dir|: numerator sign follows dir so the result is positive.
          div_req = mk_div(vrt_pkg::NUM_W'(1 << vrt_pkg::FRAC), d[ax]);
          div_req.num_neg = cur_d[17];
        end
      end
      S_WALK_RD: begin
        if (guard != vrt_pkg::GUARD_W'(vrt_pkg::GUARD_LIMIT) && !out_of_grid) begin
          grid_req.rd   = 1'b1;
          grid_req.addr = {cpos[2][vrt_pkg::CW-1:0], cpos[1][vrt_pkg::CW-1:0],
                           cpos[0][vrt_pkg::CW-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= '0;
      guard <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            ax <= '0;
            if (item.req_type == vrt_pkg::REQ_WRITE) begin
              state <= in_size ? S_WR_RD : S_DONE;
            end else begin
              state <= any_zero ? S_DONE : S_SLAB;
            end
          end
        end
        S_WR_RD: state <= S_WR_WB;
        S_WR_WB: state <= S_DONE;
        S_SLAB: begin
          if (!d_zero) begin
            state <= S_SLAB_T0;
          end else if (par_out) begin
            state <= S_DONE;
          end else if (ax == vrt_pkg::AXIS_Z) begin
            ax    <= '0;
            state <= S_ENT_MUL;
          end else begin
            ax <= ax + 1'b1;
          end
        end
        S_SLAB_T0: if (div_rsp.done) state <= S_SLAB_T1;
        S_SLAB_T1: if (div_rsp.done) state <= S_SLAB_UPD;
        S_SLAB_UPD: begin
          if (ntmin > ntmax) begin
            state <= S_DONE;
          end else if (ax == vrt_pkg::AXIS_Z) begin
            ax    <= '0;
            state <= S_ENT_MUL;
          end else begin
            ax    <= ax + 1'b1;
            state <= S_SLAB;
          end
        end
        S_ENT_MUL: state <= S_ENT_CELL;
        S_ENT_CELL: begin
          if (!d_zero) begin
            state <= S_ENT_TN;
          end else if (ax == vrt_pkg::AXIS_Z) begin
            guard <= '0;
            state <= S_WALK_RD;
          end else begin
            ax    <= ax + 1'b1;
            state <= S_ENT_MUL;
          end
        end
        S_ENT_TN: if (div_rsp.done) state <= S_ENT_TD;
        S_ENT_TD: begin
          if (div_rsp.done) begin
            if (ax == vrt_pkg::AXIS_Z) begin
              guard <= '0;
              state <= S_WALK_RD;
            end else begin
              ax    <= ax + 1'b1;
              state <= S_ENT_MUL;
            end
          end
        end
        S_WALK_RD: begin
          if (guard == vrt_pkg::GUARD_W'(vrt_pkg::GUARD_LIMIT) || out_of_grid) begin
            state <= S_DONE;
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (occ_bit || cur_new > tmax) begin
            state <= S_DONE;
          end else begin
            guard <= guard + 1'b1;
            state <= S_WALK_RD;
          end
        end
        S_DONE: if (res_ack) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          wx        <= item.cell_x;
          wy        <= item.cell_y;
          wz        <= item.cell_z;
          wcolor    <= item.cell_color;
          o         <= {item.origin_z, item.origin_y, item.origin_x};
          d         <= {item.dir_z, item.dir_y, item.dir_x};
          tmin      <= '0;
          tmax      <= $signed({32'b0, item.max_t});
          face_axis <= vrt_pkg::AXIS_Z;
          face_sign <= vrt_pkg::FACE_POS;
          res       <= '0;
        end
      end
      S_SLAB_T0: if (div_rsp.done) t0 <= div_rsp.quo;
      S_SLAB_T1: if (div_rsp.done) t1 <= div_rsp.quo;
      S_SLAB_UPD: begin
        if (lo > tmin) begin
          face_axis <= ax;
          face_sign <= lo_sign;
        end
        tmin <= ntmin;
        tmax <= ntmax;
      end
      S_ENT_MUL: begin
        prod <= cur_d * $signed({1'b0, tmin[31:0]});
      end
      S_ENT_CELL: begin
        cpos[ax] <= $signed({1'b0, cval});
        if (d_zero) begin
          tnext[ax]  <= vrt_pkg::NO_BOUNDARY;
          tdelta[ax] <= '0;
        end
        cur <= tmin;
      end
      S_ENT_TN: if (div_rsp.done) tnext[ax] <= div_rsp.quo;
      S_ENT_TD: if (div_rsp.done) tdelta[ax] <= div_rsp.quo;
      S_WALK_CHK: begin
        if (occ_bit) begin
          res.hit       <= 1'b1;
          res.hit_t     <= t_sat;
          res.hit_color <= grid_color;
          res.face_axis <= face_axis;
          res.face_sign <= face_sign;
          res.hit_x     <= cpos[0][4:0];
          res.hit_y     <= cpos[1][4:0];
          res.hit_z     <= cpos[2][4:0];
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (k == 2'(i)) begin
              if (d[i][17]) begin
                cpos[i] <= cpos[i] - 1'b1;
              end else if (d[i] != '0) begin
                cpos[i] <= cpos[i] + 1'b1;
              end
              tnext[i] <= tnext[i] + tdelta[i];
              if (d[i][17]) begin
                face_sign <= vrt_pkg::FACE_POS;
              end else if (d[i] != '0) begin
                face_sign <= vrt_pkg::FACE_NEG;
              end else begin
                face_sign <= vrt_pkg::FACE_NONE;
              end
            end
          end
          cur       <= cur_new;
          face_axis <= k;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

endmodule

### src/voxel_ray_traversal.sv
// ============================================================================
// voxel_ray_traversal
// Voxel grid ray caster with APB size registers and valid/ready channels.
// ============================================================================
// One request is worked on at a time and gives exactly one result. A voxel
// write goes through a row read, a row write-back and the result. A ray needs
// up to twelve divisions on the shared one-bit-a-cycle divider, each with
// start and hand-back (two per clipping slab, two per moving axis for the
// first boundary and the step), entry setup, then the states WALK_RD and
// WALK_CHK for each visited cell, one grid memory read each, up to 100 cells.
// After reset the occupancy memory is cleared one row a cycle, all 1024
// rows, and no request is taken during that time. A result waits in an
// output register, so the next request may be taken while it is unclaimed.
`include "voxel_ray_traversal_assert.svh"

module voxel_ray_traversal (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [4:0]                    cell_x,
  input  logic [4:0]                    cell_y,
  input  logic [4:0]                    cell_z,
  input  logic [31:0]                   cell_color,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic signed [31:0]            origin_z,
  input  logic signed [17:0]            dir_x,
  input  logic signed [17:0]            dir_y,
  input  logic signed [17:0]            dir_z,
  input  logic [31:0]                   max_t,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [31:0]                   hit_t,
  output logic [31:0]                   hit_color,
  output logic [1:0]                    face_axis,
  output logic signed [1:0]             face_sign,
  output logic [4:0]                    hit_x,
  output logic [4:0]                    hit_y,
  output logic [4:0]                    hit_z
);

  logic [vrt_pkg::SIZE_W-1:0]          size_x, size_y, size_z;
  logic [2:0][vrt_pkg::SIZE_W-1:0]     sz;
  logic                                cfg_wr;
  logic                                in_fire;
  logic                                ctrl_idle;
  logic                                clearing;
  logic                                occ_bit;
  logic [31:0]                         grid_color;
  logic                                res_valid;
  logic                                res_ack;
  vrt_pkg::item_t                      item;
  vrt_pkg::res_t                       res;
  vrt_pkg::grid_req_t                  grid_req;
  vrt_pkg::div_req_t                   div_req;
  vrt_pkg::div_rsp_t                   div_rsp;

  // Size registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= vrt_pkg::SIZE_W'(32);
      size_y <= vrt_pkg::SIZE_W'(32);
      size_z <= vrt_pkg::SIZE_W'(32);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        vrt_pkg::REG_SIZE_X: size_x <= pwdata[vrt_pkg::SIZE_W-1:0];
        vrt_pkg::REG_SIZE_Y: size_y <= pwdata[vrt_pkg::SIZE_W-1:0];
        vrt_pkg::REG_SIZE_Z: size_z <= pwdata[vrt_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vrt_pkg::REG_SIZE_X: prdata = {{(32 - vrt_pkg::SIZE_W){1'b0}}, size_x};
      vrt_pkg::REG_SIZE_Y: prdata = {{(32 - vrt_pkg::SIZE_W){1'b0}}, size_y};
      vrt_pkg::REG_SIZE_Z: prdata = {{(32 - vrt_pkg::SIZE_W){1'b0}}, size_z};
      default:             prdata = '0;
    endcase
  end

  // Sizes above the grid capacity are used as the capacity.
  always_comb begin
    sz[0] = (size_x > vrt_pkg::SIZE_W'(vrt_pkg::MAX_DIM)) ?
            vrt_pkg::SIZE_W'(vrt_pkg::MAX_DIM) : size_x;
    sz[1] = (size_y > vrt_pkg::SIZE_W'(vrt_pkg::MAX_DIM)) ?
            vrt_pkg::SIZE_W'(vrt_pkg::MAX_DIM) : size_y;
    sz[2] = (size_z > vrt_pkg::SIZE_W'(vrt_pkg::MAX_DIM)) ?
            vrt_pkg::SIZE_W'(vrt_pkg::MAX_DIM) : size_z;
  end

  // Request intake.
  assign in_ready = ctrl_idle && !clearing;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    item.req_type   = req_type;
    item.cell_x     = cell_x;
    item.cell_y     = cell_y;
    item.cell_z     = cell_z;
    item.cell_color = cell_color;
    item.origin_x   = origin_x;
    item.origin_y   = origin_y;
    item.origin_z   = origin_z;
    item.dir_x      = dir_x;
    item.dir_y      = dir_y;
    item.dir_z      = dir_z;
    item.max_t      = max_t;
  end

  vrt_grid u_grid (
    .clk      (clk),
    .rst      (rst),
    .req      (grid_req),
    .occ_bit  (occ_bit),
    .color    (grid_color),
    .clearing (clearing)
  );

  vrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  vrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .item       (item),
    .sz         (sz),
    .idle       (ctrl_idle),
    .grid_req   (grid_req),
    .occ_bit    (occ_bit),
    .grid_color (grid_color),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .res_valid  (res_valid),
    .res        (res),
    .res_ack    (res_ack)
  );

  // Output register.
  assign res_ack = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      hit       <= res.hit;
      hit_t     <= res.hit_t;
      hit_color <= res.hit_color;
      face_axis <= res.face_axis;
      face_sign <= res.face_sign;
      hit_x     <= res.hit_x;
      hit_y     <= res.hit_y;
      hit_z     <= res.hit_z;
    end
  end

  // Checks.
  `VRT_IMPLY(a_no_request_while_clearing, clearing, !in_ready, "request taken during clear")
  `VRT_IMPLY(a_div_start_when_free, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `VRT_IMPLY(a_miss_is_clean, out_valid && !hit, face_sign == vrt_pkg::FACE_NONE && hit_t == 32'd0, "miss result not clear")
  `VRT_IMPLY(a_hit_has_face, out_valid && hit, face_sign != vrt_pkg::FACE_NONE, "hit without entry face")

endmodule
